@@ rtl/core/svpwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package svpwm_pkg;

  localparam int unsigned COMPARE_WIDTH_DEF = 16;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned HP_W   = 15;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned SEC_W  = 3;
  localparam int unsigned RES_W  = 16;

  // sqrt(3)/2 in signed q1.16
  localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

  // u1, u2, u3 and phase terms in q.30 with headroom
  localparam int unsigned U2_W = 34;
  localparam int unsigned T_W  = 36;
  localparam int unsigned P_W  = T_W + GAIN_W + 1;
  localparam int unsigned FRAC = 44;
  localparam int unsigned V_W  = FRAC + 1 + HP_W + 1;
  localparam int unsigned Q_W  = V_W - FRAC;

  localparam logic [GAIN_W-1:0] DUTY_GAIN_RST   = 16'd16384;
  localparam logic [HP_W-1:0]   HALF_PERIOD_RST = 15'd1000;

  localparam logic CFG_DUTY_GAIN   = 1'b0;
  localparam logic CFG_HALF_PERIOD = 1'b1;

  typedef struct packed {
    logic ld_p;
    logic ld_v;
    logic ld_o;
  } svpwm_lane_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/svpwm_duty_generator.sv @@
// seven-segment space vector pwm duty generator
// input channel: in_valid_i / in_ready_o with ualpha_i, ubeta_i (signed q2.14,
// udc/sqrt3 = 1). a transfer happens on a rising edge with valid and ready high.
// output channel: out_valid_o / out_ready_i with sector_o (1..6) and
// compare_a_o, compare_b_o, compare_c_o, each clamped to 0..2*half_period.
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 duty_gain, 1 half_period) in the same cycle; write only while idle.
// throughput: one vector per cycle while out_ready_i is high; the five-stage
// pipeline (u2 term, sector and phase terms, gain multiply, half-period
// multiply, offset and clamp) is fully overlapped.
// stall: when out_ready_i is low the result holds; empty stages still fill,
// so the pipeline holds up to five vectors before in_ready_o drops.
// reset: rst_ni low empties the pipeline and restores duty_gain 1.0 and
// half_period 1000.
`timescale 1ns / 1ps
`default_nettype none

module svpwm_duty_generator import svpwm_pkg::*; #(
  parameter int unsigned COMPARE_WIDTH = COMPARE_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [IN_W-1:0]   ualpha_i,
  input  wire logic signed [IN_W-1:0]   ubeta_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [SEC_W-1:0]              sector_o,
  output logic [COMPARE_WIDTH-1:0]      compare_a_o,
  output logic [COMPARE_WIDTH-1:0]      compare_b_o,
  output logic [COMPARE_WIDTH-1:0]      compare_c_o
);

  logic [GAIN_W-1:0] gain_q;
  logic [HP_W-1:0]   hp_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [IN_W-1:0] beta1_q;
  logic signed [U2_W-1:0] u2_d, u2_q;

  logic signed [T_W-1:0] u1, u2, u3;
  logic signed [T_W-1:0] ta_d, tb_d, tc_d, ta_q, tb_q, tc_q;
  logic [SEC_W-1:0]      sec_d, sec2_q, sec3_q, sec4_q, sec5_q;

  svpwm_lane_ctrl_t lane_ctrl;

  // pipeline control, a stage loads when it is empty or its successor moves
  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign lane_ctrl.ld_p = rdy3;
  assign lane_ctrl.ld_v = rdy4;
  assign lane_ctrl.ld_o = rdy5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      gain_q <= DUTY_GAIN_RST;
      hp_q   <= HALF_PERIOD_RST;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DUTY_GAIN:   gain_q <= cfg_wdata_i;
          CFG_HALF_PERIOD: hp_q   <= cfg_wdata_i[HP_W-1:0];
          default:         gain_q <= gain_q;
        endcase
      end
    end
  end

  // stage 1: u2 = beta/2 + alpha*sqrt(3)/2
  assign u2_d = $signed({ubeta_i, 15'b0}) + ualpha_i * SQRT3_HALF_Q16;

  // stage 2: u3, sector and phase terms
  assign u1 = $signed({{(T_W-IN_W-16){beta1_q[IN_W-1]}}, beta1_q, 16'b0});
  assign u2 = T_W'(u2_q);
  assign u3 = u2 - u1;

  always_comb begin
    sec_d = 3'd3 - SEC_W'(u2 > 0) - SEC_W'(u3 > 0);
    if (u1 < 0) begin
      sec_d = 3'd7 - sec_d;
    end
    case (sec_d)
      3'd1, 3'd4: begin
        ta_d = u2;
        tb_d = u1 - u3;
        tc_d = -u2;
      end
      3'd2, 3'd5: begin
        ta_d = u3 + u2;
        tb_d = u1;
        tc_d = -u1;
      end
      default: begin
        ta_d = u3;
        tb_d = -u3;
        tc_d = -(u1 + u2);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      beta1_q <= ubeta_i;
      u2_q    <= u2_d;
    end
    if (rdy2) begin
      ta_q   <= ta_d;
      tb_q   <= tb_d;
      tc_q   <= tc_d;
      sec2_q <= sec_d;
    end
    if (rdy3) sec3_q <= sec2_q;
    if (rdy4) sec4_q <= sec3_q;
    if (rdy5) sec5_q <= sec4_q;
  end

  svpwm_cmp_lane #(.COMPARE_WIDTH(COMPARE_WIDTH)) u_lane_a (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .t_i       (ta_q),
    .gain_i    (gain_q),
    .hp_i      (hp_q),
    .compare_o (compare_a_o)
  );

  svpwm_cmp_lane #(.COMPARE_WIDTH(COMPARE_WIDTH)) u_lane_b (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .t_i       (tb_q),
    .gain_i    (gain_q),
    .hp_i      (hp_q),
    .compare_o (compare_b_o)
  );

  svpwm_cmp_lane #(.COMPARE_WIDTH(COMPARE_WIDTH)) u_lane_c (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .t_i       (tc_q),
    .gain_i    (gain_q),
    .hp_i      (hp_q),
    .compare_o (compare_c_o)
  );

  assign out_valid_o = v5_q;
  assign sector_o    = sec5_q;

`ifndef SYNTHESIS
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sector_o != 3'd0 && sector_o != 3'd7))
    else $error("sector out of range");

  a_compare_a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (RES_W'(compare_a_o) <= {hp_q, 1'b0}))
    else $error("phase a compare above full period");

  a_compare_c_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (RES_W'(compare_c_o) <= {hp_q, 1'b0}))
    else $error("phase c compare above full period");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted transfer lost at stage one");
`endif

endmodule

`default_nettype wire

@@ rtl/core/svpwm_cmp_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svpwm_cmp_lane import svpwm_pkg::*; #(
  parameter int unsigned COMPARE_WIDTH = COMPARE_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire svpwm_lane_ctrl_t         ctrl_i,
  input  wire logic signed [T_W-1:0]    t_i,
  input  wire logic [GAIN_W-1:0]        gain_i,
  input  wire logic [HP_W-1:0]          hp_i,
  output logic [COMPARE_WIDTH-1:0]      compare_o
);

  localparam logic [RES_W:0] LIM = (RES_W+1)'((32'd1 << COMPARE_WIDTH) - 32'd1);

  logic signed [P_W-1:0] p_d, p_q;
  logic signed [V_W-1:0] v_d, v_q;
  logic                  sat_hi_d, sat_hi_q;
  logic                  sat_lo_d, sat_lo_q;
  logic signed [Q_W-1:0] q;
  logic signed [Q_W:0]   r;
  logic signed [Q_W:0]   hp2;
  logic [RES_W-1:0]      res;
  logic [COMPARE_WIDTH-1:0] compare_d, compare_q;

  // t * gain, exact q.44
  assign p_d = t_i * $signed({1'b0, gain_i});

  // saturation and scaling by the half period
  assign sat_hi_d = !p_q[P_W-1] && (p_q[P_W-2:FRAC] != '0);
  assign sat_lo_d = p_q[P_W-1] && (p_q[P_W-2:FRAC] != '1);
  assign v_d      = $signed(p_q[FRAC:0]) * $signed({1'b0, hp_i});

  // floor, offset and clamp
  assign q   = v_q[V_W-1:FRAC];
  assign hp2 = $signed({{(Q_W-HP_W){1'b0}}, hp_i, 1'b0});
  assign r   = {q[Q_W-1], q} + $signed({{(Q_W+1-HP_W){1'b0}}, hp_i});

  always_comb begin
    if (sat_hi_q) begin
      res = RES_W'(hp2);
    end else if (sat_lo_q || r[Q_W]) begin
      res = '0;
    end else if (r > hp2) begin
      res = RES_W'(hp2);
    end else begin
      res = RES_W'(r);
    end
    if ({1'b0, res} > LIM) begin
      compare_d = COMPARE_WIDTH'(LIM);
    end else begin
      compare_d = COMPARE_WIDTH'(res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_p) begin
      p_q <= p_d;
    end
    if (ctrl_i.ld_v) begin
      v_q      <= v_d;
      sat_hi_q <= sat_hi_d;
      sat_lo_q <= sat_lo_d;
    end
    if (ctrl_i.ld_o) begin
      compare_q <= compare_d;
    end
  end

  assign compare_o = compare_q;

endmodule

`default_nettype wire
